// ===== hw/rtl/srht_pkg.sv =====
package srht_pkg;

  // Sign of one cross product: both low means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } srht_sign_t;

  // Stage advance strobes shared by every slice of the pipeline
  typedef struct packed {
    logic en1;
    logic en2;
  } srht_adv_t;

endpackage

// ===== hw/rtl/srht_if.sv =====
// Input channel: one segment and one rectangle per word
interface srht_in_if #(
  parameter int COORD_BITS = 15
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] seg_start_x;
  logic [COORD_BITS-1:0] seg_start_y;
  logic [COORD_BITS-1:0] seg_end_x;
  logic [COORD_BITS-1:0] seg_end_y;
  logic [COORD_BITS-1:0] rect_left;
  logic [COORD_BITS-1:0] rect_bottom;
  logic [COORD_BITS-1:0] rect_right;
  logic [COORD_BITS-1:0] rect_top;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           rect_left, rect_bottom, rect_right, rect_top,
    input  ready
  );

  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           rect_left, rect_bottom, rect_right, rect_top,
    output ready
  );
endinterface

// Result channel: one hit flag per word
interface srht_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

// ===== hw/rtl/segment_rectangle_hit_test.sv =====
// Segment against axis-aligned rectangle hit test.
//
// in_ch carries one word per test: segment start and end points and the
// rectangle's minimum and maximum corners, borders inclusive. out_ch
// returns one hit flag per input word, in order. Touching, collinear and
// inside-endpoint cases all count as a hit.
//
// A word passes through three register stages on its way to out_ch.
// Stage 1 forms the coordinate differences, bounding boxes and inside
// flag, stage 2 the 32 partial cross products (COORD_BITS+1 squared
// each), and stage 3 registers the hit flag built from the product
// compares. Throughput is one word per cycle while out_ch is not
// stalled; every stage takes a new word each cycle that it advances.
//
// Reset (rst_n low, synchronous) empties all stages; no result is lost
// or invented. When the receiver holds out_ch.ready low the result stays
// on out_ch; the earlier stages keep filling until every stage is full,
// and only then does in_ch.ready drop.
module segment_rectangle_hit_test #(
  parameter int COORD_BITS = 15
) (
  input  logic            clk,
  input  logic            rst_n,
  srht_in_if.sink         in_ch,
  srht_out_if.source      out_ch
);
  import srht_pkg::*;

  srht_adv_t adv;
  logic      en3;
  logic      v1_r, v2_r, v3_r;
  logic      inside_nxt, inside1_r, inside2_r;
  logic      hit_nxt, hit_r;
  logic      cross_l, cross_t, cross_r, cross_b;
  logic      in_s, in_e;

  // Advance a stage when it is empty or its successor advances
  assign en3     = !v3_r || out_ch.ready;
  assign adv.en2 = !v2_r || en3;
  assign adv.en1 = !v1_r || adv.en2;
  assign in_ch.ready = adv.en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv.en1) begin
        v1_r <= in_ch.valid;
      end
      if (adv.en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Endpoint inside the rectangle, borders included
  assign in_s = (in_ch.seg_start_x >= in_ch.rect_left) &&
                (in_ch.seg_start_x <= in_ch.rect_right) &&
                (in_ch.seg_start_y >= in_ch.rect_bottom) &&
                (in_ch.seg_start_y <= in_ch.rect_top);
  assign in_e = (in_ch.seg_end_x >= in_ch.rect_left) &&
                (in_ch.seg_end_x <= in_ch.rect_right) &&
                (in_ch.seg_end_y >= in_ch.rect_bottom) &&
                (in_ch.seg_end_y <= in_ch.rect_top);
  assign inside_nxt = in_s || in_e;

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      inside1_r <= inside_nxt;
    end
    if (adv.en2) begin
      inside2_r <= inside1_r;
    end
  end

  // Left edge: minimum corner up to top-left corner
  srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_left (
    .clk(clk), .adv(adv),
    .a_x(in_ch.seg_start_x), .a_y(in_ch.seg_start_y),
    .b_x(in_ch.seg_end_x),   .b_y(in_ch.seg_end_y),
    .c_x(in_ch.rect_left),   .c_y(in_ch.rect_bottom),
    .d_x(in_ch.rect_left),   .d_y(in_ch.rect_top),
    .crossed(cross_l)
  );

  // Top edge
  srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_top (
    .clk(clk), .adv(adv),
    .a_x(in_ch.seg_start_x), .a_y(in_ch.seg_start_y),
    .b_x(in_ch.seg_end_x),   .b_y(in_ch.seg_end_y),
    .c_x(in_ch.rect_left),   .c_y(in_ch.rect_top),
    .d_x(in_ch.rect_right),  .d_y(in_ch.rect_top),
    .crossed(cross_t)
  );

  // Right edge
  srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_right (
    .clk(clk), .adv(adv),
    .a_x(in_ch.seg_start_x), .a_y(in_ch.seg_start_y),
    .b_x(in_ch.seg_end_x),   .b_y(in_ch.seg_end_y),
    .c_x(in_ch.rect_right),  .c_y(in_ch.rect_top),
    .d_x(in_ch.rect_right),  .d_y(in_ch.rect_bottom),
    .crossed(cross_r)
  );

  // Bottom edge
  srht_edge #(.COORD_BITS(COORD_BITS)) u_edge_bottom (
    .clk(clk), .adv(adv),
    .a_x(in_ch.seg_start_x), .a_y(in_ch.seg_start_y),
    .b_x(in_ch.seg_end_x),   .b_y(in_ch.seg_end_y),
    .c_x(in_ch.rect_right),  .c_y(in_ch.rect_bottom),
    .d_x(in_ch.rect_left),   .d_y(in_ch.rect_bottom),
    .crossed(cross_b)
  );

  // Combine into the output word
  assign hit_nxt = inside2_r || cross_l || cross_t || cross_r || cross_b;

  always_ff @(posedge clk) begin
    if (en3) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid = v3_r;
  assign out_ch.hit   = hit_r;

  // Input stalls only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with an empty stage");

  // An accepted word reaches stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted word lost at stage 1");

  // A held stage 2 word stays put
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en3) |=> v2_r)
    else $error("stage 2 word dropped during stall");

  // An inside endpoint always yields a hit
  a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en3 && inside2_r) |=> (out_ch.valid && out_ch.hit))
    else $error("inside endpoint did not report a hit");

endmodule

// ===== hw/rtl/srht_turn.sv =====
module srht_turn #(
  parameter int COORD_BITS = 15
) (
  input  logic                    clk,
  input  srht_pkg::srht_adv_t     adv,
  input  logic [COORD_BITS-1:0]   o_x,
  input  logic [COORD_BITS-1:0]   o_y,
  input  logic [COORD_BITS-1:0]   q_x,
  input  logic [COORD_BITS-1:0]   q_y,
  input  logic [COORD_BITS-1:0]   r_x,
  input  logic [COORD_BITS-1:0]   r_y,
  output srht_pkg::srht_sign_t    sgn
);
  import srht_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ux_nxt, uy_nxt, vx_nxt, vy_nxt;
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r;
  logic signed [PW-1:0] l_nxt, m_nxt;
  logic signed [PW-1:0] l_r, m_r;

  // Stage 1: exact coordinate differences
  assign ux_nxt = $signed({1'b0, q_x}) - $signed({1'b0, o_x});
  assign uy_nxt = $signed({1'b0, q_y}) - $signed({1'b0, o_y});
  assign vx_nxt = $signed({1'b0, r_x}) - $signed({1'b0, o_x});
  assign vy_nxt = $signed({1'b0, r_y}) - $signed({1'b0, o_y});

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  // Stage 2: the two partial products of the cross product
  assign l_nxt = PW'(ux_r) * PW'(vy_r);
  assign m_nxt = PW'(vx_r) * PW'(uy_r);

  always_ff @(posedge clk) begin
    if (adv.en2) begin
      l_r <= l_nxt;
      m_r <= m_nxt;
    end
  end

  // Compare the products into a sign
  assign sgn.pos = (l_r > m_r);
  assign sgn.neg = (l_r < m_r);

endmodule

// ===== hw/rtl/srht_edge.sv =====
module srht_edge #(
  parameter int COORD_BITS = 15
) (
  input  logic                    clk,
  input  srht_pkg::srht_adv_t     adv,
  input  logic [COORD_BITS-1:0]   a_x,
  input  logic [COORD_BITS-1:0]   a_y,
  input  logic [COORD_BITS-1:0]   b_x,
  input  logic [COORD_BITS-1:0]   b_y,
  input  logic [COORD_BITS-1:0]   c_x,
  input  logic [COORD_BITS-1:0]   c_y,
  input  logic [COORD_BITS-1:0]   d_x,
  input  logic [COORD_BITS-1:0]   d_y,
  output logic                    crossed
);
  import srht_pkg::*;

  logic [COORD_BITS-1:0] ab_max_x, ab_min_x, ab_max_y, ab_min_y;
  logic [COORD_BITS-1:0] cd_max_x, cd_min_x, cd_max_y, cd_min_y;
  logic                  reject_nxt;
  logic                  reject1_r, reject2_r;
  srht_sign_t            s1, s2, s3, s4;
  logic                  ok_ab, ok_cd;

  // Bounding-box rejection
  assign ab_max_x = (a_x > b_x) ? a_x : b_x;
  assign ab_min_x = (a_x < b_x) ? a_x : b_x;
  assign ab_max_y = (a_y > b_y) ? a_y : b_y;
  assign ab_min_y = (a_y < b_y) ? a_y : b_y;
  assign cd_max_x = (c_x > d_x) ? c_x : d_x;
  assign cd_min_x = (c_x < d_x) ? c_x : d_x;
  assign cd_max_y = (c_y > d_y) ? c_y : d_y;
  assign cd_min_y = (c_y < d_y) ? c_y : d_y;

  assign reject_nxt = (ab_max_x < cd_min_x) || (cd_max_x < ab_min_x) ||
                      (ab_max_y < cd_min_y) || (cd_max_y < ab_min_y);

  // Carry the rejection alongside the products
  always_ff @(posedge clk) begin
    if (adv.en1) begin
      reject1_r <= reject_nxt;
    end
    if (adv.en2) begin
      reject2_r <= reject1_r;
    end
  end

  // Four orientation tests
  srht_turn #(.COORD_BITS(COORD_BITS)) u_turn1 (
    .clk(clk), .adv(adv),
    .o_x(a_x), .o_y(a_y), .q_x(b_x), .q_y(b_y), .r_x(c_x), .r_y(c_y),
    .sgn(s1)
  );
  srht_turn #(.COORD_BITS(COORD_BITS)) u_turn2 (
    .clk(clk), .adv(adv),
    .o_x(a_x), .o_y(a_y), .q_x(b_x), .q_y(b_y), .r_x(d_x), .r_y(d_y),
    .sgn(s2)
  );
  srht_turn #(.COORD_BITS(COORD_BITS)) u_turn3 (
    .clk(clk), .adv(adv),
    .o_x(c_x), .o_y(c_y), .q_x(d_x), .q_y(d_y), .r_x(a_x), .r_y(a_y),
    .sgn(s3)
  );
  srht_turn #(.COORD_BITS(COORD_BITS)) u_turn4 (
    .clk(clk), .adv(adv),
    .o_x(c_x), .o_y(c_y), .q_x(d_x), .q_y(d_y), .r_x(b_x), .r_y(b_y),
    .sgn(s4)
  );

  // Opposite sides or on the line: the sign product is not positive
  assign ok_ab = !(s1.pos && s2.pos) && !(s1.neg && s2.neg);
  assign ok_cd = !(s3.pos && s4.pos) && !(s3.neg && s4.neg);
  assign crossed = !reject2_r && ok_ab && ok_cd;

endmodule
